>>> rtl/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants and types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

    localparam int unsigned HUE_W          = 9;
    localparam int unsigned CH_W           = 8;
    localparam int unsigned RAMP_W         = 6;
    localparam int unsigned PROD_W         = 2 * CH_W;
    localparam int unsigned NUM_W          = 22;

    localparam int unsigned DEG_PER_SECTOR = 60;
    localparam int unsigned SECTOR_COUNT   = 6;
    localparam int unsigned HUE_TURN       = DEG_PER_SECTOR * SECTOR_COUNT;
    localparam int unsigned FULL_SCALE     = 255;
    localparam int unsigned OUT_DIVISOR    = FULL_SCALE * DEG_PER_SECTOR;

    // floor(2^RECIP_SHIFT / OUT_DIVISOR); estimate is low by at most one
    localparam int unsigned RECIP_SHIFT    = NUM_W;
    localparam int unsigned RECIP_W        = 9;
    localparam int unsigned RECIP_MULT     = (1 << RECIP_SHIFT) / OUT_DIVISOR;

    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } sector_t;

endpackage

>>> rtl/hsv2rgb_div.sv
// ----------------------------------------------------------------------------
// hsv2rgb_div
// Divide by the output scale: registered reciprocal estimate, then one
// compare-and-increment correction on the registered numerator.
// ----------------------------------------------------------------------------
module hsv2rgb_div (
    input  logic                          clk,
    input  logic                          load,
    input  logic [hsv2rgb_pkg::NUM_W-1:0] num,
    output logic [hsv2rgb_pkg::CH_W-1:0]  quot
);
    import hsv2rgb_pkg::*;

    localparam int unsigned EST_W = NUM_W + RECIP_W;

    logic [EST_W-1:0] est_prod;
    logic [CH_W-1:0]  est_reg;
    logic [CH_W-1:0]  est_next;
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] back_prod;
    logic [NUM_W-1:0] rem;

    assign est_prod = {{RECIP_W{1'b0}}, num} * EST_W'(RECIP_MULT);
    assign est_next = est_prod[RECIP_SHIFT +: CH_W];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            est_reg <= est_next;
            num_reg <= num;
        end
    end

    assign back_prod = {{(NUM_W-CH_W){1'b0}}, est_reg} * NUM_W'(OUT_DIVISOR);
    assign rem       = num_reg - back_prod;
    assign quot      = (rem >= NUM_W'(OUT_DIVISOR)) ? est_reg + CH_W'(1) : est_reg;

endmodule

>>> rtl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming HSV to RGB color conversion, one color per clock while out_ready holds.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_ready with hue_deg (0..359, larger values wrap
// by one turn), saturation and brightness (255 = 1.0).
// Output channel: out_valid/out_ready with red, green and blue, each
// floor(255*(channel + m)) computed exactly; the largest equals brightness.
// Five register stages: hue sector, two products, channel sums, quotient
// estimate, corrected quotient and channel mapping. A request passes through
// them in that order and is taken from the last.
// Throughput is one request per cycle while out_ready holds; every stage has its own valid bit.
// When the receiver stalls, results hold in place and bubbles close up;
// in_ready drops only once all five stages hold a request.
// Reset empties the pipeline by clearing the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hsv2rgb_pkg::HUE_W-1:0] hue_deg,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  saturation,
    input  logic [hsv2rgb_pkg::CH_W-1:0]  brightness,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hsv2rgb_pkg::CH_W-1:0]  red,
    output logic [hsv2rgb_pkg::CH_W-1:0]  green,
    output logic [hsv2rgb_pkg::CH_W-1:0]  blue
);
    import hsv2rgb_pkg::*;

    localparam int unsigned STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stage_ready;
    logic [STAGES-1:0] stage_load;
    logic [STAGES-1:0] upstream_valid;

    // stage 1
    logic [HUE_W-1:0]  hue_wrap;
    logic [HUE_W-1:0]  sector_base;
    logic [RAMP_W-1:0] frac;
    sector_t           sector_next;
    logic [RAMP_W-1:0] ramp_next;
    sector_t           s1_sector_reg;
    logic [RAMP_W-1:0] s1_ramp_reg;
    logic [CH_W-1:0]   s1_val_reg;
    logic [CH_W-1:0]   s1_sat_reg;

    // stage 2
    sector_t           s2_sector_reg;
    logic [RAMP_W-1:0] s2_ramp_reg;
    logic [CH_W-1:0]   s2_val_reg;
    logic [PROD_W-1:0] s2_vs_reg;
    logic [PROD_W-1:0] s2_vl_reg;

    // stage 3
    logic [NUM_W-1:0]  n_low_next;
    logic [NUM_W-1:0]  n_mid_next;
    sector_t           s3_sector_reg;
    logic [CH_W-1:0]   s3_val_reg;
    logic [NUM_W-1:0]  s3_mid_reg;
    logic [NUM_W-1:0]  s3_low_reg;

    // stage 4
    sector_t           s4_sector_reg;
    logic [CH_W-1:0]   s4_val_reg;
    logic [CH_W-1:0]   mid_q;
    logic [CH_W-1:0]   low_q;

    // stage 5
    logic [CH_W-1:0]   red_next;
    logic [CH_W-1:0]   green_next;
    logic [CH_W-1:0]   blue_next;
    logic [CH_W-1:0]   red_reg;
    logic [CH_W-1:0]   green_reg;
    logic [CH_W-1:0]   blue_reg;

    // pipeline control
    assign upstream_valid = {valid_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign stage_load = stage_ready & upstream_valid;
    assign valid_next = (stage_ready & upstream_valid) | (~stage_ready & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];

    // stage 1: hue wrap, sector and ramp
    assign hue_wrap = (hue_deg >= HUE_W'(HUE_TURN)) ? hue_deg - HUE_W'(HUE_TURN) : hue_deg;

    always_comb
    begin
        priority if (hue_wrap < HUE_W'(1 * DEG_PER_SECTOR))
        begin
            sector_next = SEC_RED_YELLOW;
            sector_base = '0;
        end
        else if (hue_wrap < HUE_W'(2 * DEG_PER_SECTOR))
        begin
            sector_next = SEC_YELLOW_GREEN;
            sector_base = HUE_W'(1 * DEG_PER_SECTOR);
        end
        else if (hue_wrap < HUE_W'(3 * DEG_PER_SECTOR))
        begin
            sector_next = SEC_GREEN_CYAN;
            sector_base = HUE_W'(2 * DEG_PER_SECTOR);
        end
        else if (hue_wrap < HUE_W'(4 * DEG_PER_SECTOR))
        begin
            sector_next = SEC_CYAN_BLUE;
            sector_base = HUE_W'(3 * DEG_PER_SECTOR);
        end
        else if (hue_wrap < HUE_W'(5 * DEG_PER_SECTOR))
        begin
            sector_next = SEC_BLUE_MAGENTA;
            sector_base = HUE_W'(4 * DEG_PER_SECTOR);
        end
        else
        begin
            sector_next = SEC_MAGENTA_RED;
            sector_base = HUE_W'(5 * DEG_PER_SECTOR);
        end
    end

    assign frac      = RAMP_W'(hue_wrap - sector_base);
    assign ramp_next = sector_next[0] ? RAMP_W'(DEG_PER_SECTOR) - frac : frac;

    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            s1_sector_reg <= sector_next;
            s1_ramp_reg   <= ramp_next;
            s1_val_reg    <= brightness;
            s1_sat_reg    <= saturation;
        end
    end

    // stage 2: value times saturation and its complement
    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_ramp_reg   <= s1_ramp_reg;
            s2_val_reg    <= s1_val_reg;
            s2_vs_reg     <= {{CH_W{1'b0}}, s1_val_reg} * {{CH_W{1'b0}}, s1_sat_reg};
            s2_vl_reg     <= {{CH_W{1'b0}}, s1_val_reg}
                             * {{CH_W{1'b0}}, CH_W'(FULL_SCALE) - s1_sat_reg};
        end
    end

    // stage 3: channel sums in units of 1/(255*255*60)
    assign n_low_next = {{(NUM_W-PROD_W){1'b0}}, s2_vl_reg} * NUM_W'(DEG_PER_SECTOR);
    assign n_mid_next = {{(NUM_W-PROD_W){1'b0}}, s2_vs_reg}
                        * {{(NUM_W-RAMP_W){1'b0}}, s2_ramp_reg} + n_low_next;

    always_ff @(posedge clk)
    begin
        if (stage_load[2])
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s3_mid_reg    <= n_mid_next;
            s3_low_reg    <= n_low_next;
        end
    end

    // stage 4: quotient estimate, corrected on the way into stage 5
    hsv2rgb_div u_div_mid (
        .clk  (clk),
        .load (stage_load[3]),
        .num  (s3_mid_reg),
        .quot (mid_q)
    );

    hsv2rgb_div u_div_low (
        .clk  (clk),
        .load (stage_load[3]),
        .num  (s3_low_reg),
        .quot (low_q)
    );

    always_ff @(posedge clk)
    begin
        if (stage_load[3])
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
        end
    end

    // stage 5: channel mapping into the output register
    always_comb
    begin
        unique case (s4_sector_reg)
            SEC_RED_YELLOW:
            begin
                red_next = s4_val_reg; green_next = mid_q; blue_next = low_q;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next = mid_q; green_next = s4_val_reg; blue_next = low_q;
            end
            SEC_GREEN_CYAN:
            begin
                red_next = low_q; green_next = s4_val_reg; blue_next = mid_q;
            end
            SEC_CYAN_BLUE:
            begin
                red_next = low_q; green_next = mid_q; blue_next = s4_val_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next = mid_q; green_next = low_q; blue_next = s4_val_reg;
            end
            default:
            begin
                red_next = s4_val_reg; green_next = low_q; blue_next = mid_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // checks
    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (s1_ramp_reg <= RAMP_W'(DEG_PER_SECTOR)))
        else $error("ramp beyond one sector");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted request did not enter stage 1");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && !stage_ready[3]) |=> (valid_reg[2] && $stable(s3_mid_reg)))
        else $error("stalled stage 3 request lost or changed");

    a_low_le_mid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> (low_q <= mid_q && mid_q <= s4_val_reg))
        else $error("channel ordering broken");

endmodule
